// File: design/hmlf_pkg.sv
// Package for the HTTP message length framer: item types, parse state,
// keyword table and character helpers. No dependencies.
package hmlf_pkg;

    localparam int HEADER_COUNT_BITS = 16;
    localparam int KEYWORD_LEN       = 15;
    localparam int KW_POS_BITS       = 4;
    localparam int ACC_BITS          = 32;
    localparam int ACC_X10_BITS      = ACC_BITS + 3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    localparam logic [ACC_X10_BITS-1:0] LIMIT_POS = ACC_X10_BITS'(32'h7FFF_FFFF);
    localparam logic [ACC_X10_BITS-1:0] LIMIT_NEG = ACC_X10_BITS'(32'h8000_0000);

    typedef enum logic [3:0] {
        TP_NONE   = 4'b0001,
        TP_CR     = 4'b0010,
        TP_CRLF   = 4'b0100,
        TP_CRLFCR = 4'b1000
    } t_term_progress;

    typedef enum logic [3:0] {
        VP_IDLE   = 4'b0001,
        VP_SKIP   = 4'b0010,
        VP_DIGITS = 4'b0100,
        VP_DONE   = 4'b1000
    } t_value_phase;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       msg_start;
    } t_in_item;

    typedef struct packed {
        logic signed [32:0] total_length;
        logic [15:0]        header_length;
        logic signed [31:0] body_length;
        logic               length_present;
        logic               header_saturated;
        logic               value_saturated;
    } t_out_item;

    typedef struct packed {
        logic [HEADER_COUNT_BITS-1:0] header_count;
        t_term_progress               terminator_progress;
        logic                         keyword_active;
        logic [KW_POS_BITS-1:0]       keyword_position;
        logic                         field_found;
        t_value_phase                 value_phase;
        logic                         value_negative;
        logic [ACC_BITS-1:0]          value_accumulator;
        logic                         value_overflow;
        logic                         count_overflow;
        logic                         header_done;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        header_count:        '0,
        terminator_progress: TP_NONE,
        keyword_active:      1'b0,
        keyword_position:    '0,
        field_found:         1'b0,
        value_phase:         VP_IDLE,
        value_negative:      1'b0,
        value_accumulator:   '0,
        value_overflow:      1'b0,
        count_overflow:      1'b0,
        header_done:         1'b0
    };

    // "content-length:" one character per position
    function automatic logic [7:0] keyword_char(input logic [KW_POS_BITS-1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h6C; // l
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            4'd14:   ch = 8'h3A; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// File: design/hmlf_in_if.sv
// Input request channel of the length framer: valid, ready, byte payload.
// Depends on hmlf_pkg.
interface hmlf_in_if
    import hmlf_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/hmlf_out_if.sv
// Result request channel of the length framer: valid, ready, lengths payload.
// Depends on hmlf_pkg.
interface hmlf_out_if
    import hmlf_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/hmlf_step.sv
// Per-byte next-state logic: terminator tracking, keyword match, value parse.
// Depends on hmlf_pkg.
module hmlf_step
    import hmlf_pkg::*;
(
    input  t_parse_state i_state,
    input  t_in_item     i_item,
    output t_parse_state o_state,
    output logic         o_finished,
    output t_out_item    o_result
);

    localparam logic [HEADER_COUNT_BITS-1:0] COUNT_MAX = '1;

    t_parse_state       s;
    t_parse_state       n;
    logic [7:0]         c;
    logic               digit;
    logic [ACC_X10_BITS-1:0] acc_ext;
    logic [ACC_X10_BITS-1:0] acc_next;
    logic [ACC_X10_BITS-1:0] limit;
    logic [ACC_BITS-1:0]     acc_sat;
    logic               sat_hit;
    logic [ACC_BITS-1:0]     body;
    logic               finished;

    assign s     = i_item.msg_start ? PARSE_RESET : i_state;
    assign c     = i_item.byte_value;
    assign digit = is_digit(c);

    // acc * 10 + digit, saturating at the signed limit for the current sign
    assign acc_ext  = ACC_X10_BITS'(s.value_accumulator);
    assign acc_next = (acc_ext << 3) + (acc_ext << 1) + ACC_X10_BITS'(c - CH_ZERO);
    assign limit    = s.value_negative ? LIMIT_NEG : LIMIT_POS;
    assign sat_hit  = acc_next > limit;
    assign acc_sat  = sat_hit ? ACC_BITS'(limit) : ACC_BITS'(acc_next);

    always_comb begin
        n        = s;
        finished = 1'b0;
        if (!s.header_done) begin
            if (s.header_count == COUNT_MAX) begin
                n.count_overflow = 1'b1;
            end else begin
                n.header_count = s.header_count + 1'b1;
            end

            if (s.field_found) begin
                unique case (s.value_phase)
                    VP_SKIP: begin
                        if (is_space(c)) begin
                            n.value_phase = VP_SKIP;
                        end else if (c == CH_PLUS || c == CH_MINUS) begin
                            n.value_negative = (c == CH_MINUS);
                            n.value_phase    = VP_DIGITS;
                        end else if (digit) begin
                            n.value_phase       = VP_DIGITS;
                            n.value_accumulator = acc_sat;
                            n.value_overflow    = s.value_overflow | sat_hit;
                        end else begin
                            n.value_phase = VP_DONE;
                        end
                    end
                    VP_DIGITS: begin
                        if (digit) begin
                            n.value_accumulator = acc_sat;
                            n.value_overflow    = s.value_overflow | sat_hit;
                        end else begin
                            n.value_phase = VP_DONE;
                        end
                    end
                    VP_IDLE, VP_DONE: n.value_phase = s.value_phase;
                    default:          n.value_phase = s.value_phase;
                endcase
            end else if (s.keyword_active) begin
                if (to_lower(c) != keyword_char(s.keyword_position)) begin
                    n.keyword_active = 1'b0;
                end else if (s.keyword_position >= KW_POS_BITS'(KEYWORD_LEN - 1)) begin
                    n.keyword_active = 1'b0;
                    n.field_found    = 1'b1;
                    n.value_phase    = VP_SKIP;
                end else begin
                    n.keyword_position = s.keyword_position + 1'b1;
                end
            end

            // terminator tracking; a line start after CR LF arms the keyword match
            if (c == CH_CR) begin
                n.terminator_progress = (s.terminator_progress == TP_CRLF) ? TP_CRLFCR : TP_CR;
            end else if (c == CH_LF) begin
                if (s.terminator_progress == TP_CR) begin
                    n.terminator_progress = TP_CRLF;
                    if (!n.field_found) begin
                        n.keyword_active   = 1'b1;
                        n.keyword_position = '0;
                    end
                end else if (s.terminator_progress == TP_CRLFCR) begin
                    n.terminator_progress = TP_NONE;
                    n.header_done         = 1'b1;
                    finished              = 1'b1;
                end else begin
                    n.terminator_progress = TP_NONE;
                end
            end else begin
                n.terminator_progress = TP_NONE;
            end
        end
    end

    always_comb begin
        body = '0;
        if (n.field_found) begin
            body = n.value_negative ? (ACC_BITS'(0) - n.value_accumulator)
                                    : n.value_accumulator;
        end
    end

    assign o_state    = n;
    assign o_finished = finished;

    assign o_result.total_length     = $signed(33'(n.header_count) + {body[31], body});
    assign o_result.header_length    = 16'(n.header_count);
    assign o_result.body_length      = $signed(body);
    assign o_result.length_present   = n.field_found;
    assign o_result.header_saturated = n.count_overflow;
    assign o_result.value_saturated  = n.value_overflow;

endmodule

// File: design/http_message_length_framer.sv
// Top level of the HTTP message length framer: input register, parse state,
// result register. Depends on hmlf_pkg, hmlf_in_if, hmlf_out_if, hmlf_step.
//
//  port    dir  handshake     payload
//  i_in    in   valid/ready   byte_value[7:0], msg_start
//  o_out   out  valid/ready   total_length[32:0] s, header_length[15:0],
//                             body_length[31:0] s, length_present,
//                             header_saturated, value_saturated
//
// One byte per cycle while o_out is not stalled: a request is captured in the
// input register, then the byte updates the parse state and, on the byte
// closing CR LF CR LF, loads the result register in the same cycle.
// i_rst_n (synchronous, active low) clears the parse state and both valids.
// A stalled result holds the result register; the input register drains into
// the parse state whenever the result register is free or being taken, so
// i_in.ready only drops while both registers are full and o_out is stalled.
// After the terminator, bytes are consumed silently until msg_start is seen.
module http_message_length_framer
    import hmlf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    hmlf_in_if.sink           i_in,
    hmlf_out_if.source        o_out
);

    // input stage
    logic         r_in_valid;
    t_in_item     r_in_item;

    // parse state
    t_parse_state r_state;
    t_parse_state n_state;

    // result stage
    logic         r_out_valid;
    t_out_item    r_out_item;
    t_out_item    n_out_item;

    logic         step_finished;
    logic         out_free;
    logic         advance;

    hmlf_step u_step (
        .i_state    (r_state),
        .i_item     (r_in_item),
        .o_state    (n_state),
        .o_finished (step_finished),
        .o_result   (n_out_item)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.payload;
        end
    end

    // state moves only when the held byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && step_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_finished) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

endmodule

// File: bench/hmlf_checker.sv
// Checker for the HTTP message length framer: watches both request channels,
// predicts the length result of every header and compares it field by field.
// Depends on hmlf_pkg, hmlf_in_if and hmlf_out_if.
module hmlf_checker
    import hmlf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    hmlf_in_if   i_in_mon,
    hmlf_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8*KEYWORD_LEN-1:0] LENGTH_FIELD = "content-length:";

    // predicted parse state
    logic [HEADER_COUNT_BITS-1:0] hdr_bytes;
    t_term_progress               term_seen;
    logic                         name_armed;
    logic [KW_POS_BITS-1:0]       name_pos;
    logic                         length_seen;
    t_value_phase                 num_phase;
    logic                         num_neg;
    logic [31:0]                  num_mag;
    logic                         num_sat;
    logic                         cnt_sat;
    logic                         hdr_closed;

    t_out_item pending_lengths[$];
    int        mismatches = 0;

    function automatic void clear_parse();
        hdr_bytes   = '0;
        term_seen   = TP_NONE;
        name_armed  = 1'b0;
        name_pos    = '0;
        length_seen = 1'b0;
        num_phase   = VP_IDLE;
        num_neg     = 1'b0;
        num_mag     = '0;
        num_sat     = 1'b0;
        cnt_sat     = 1'b0;
        hdr_closed  = 1'b0;
    endfunction

    // atoi-like value scan: whitespace, optional sign, digits
    function automatic void scan_value_char(input logic [7:0] c);
        logic        is_dig;
        logic        is_ws;
        logic        add;
        logic [63:0] next_mag;
        logic [63:0] cap;
        is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
        is_ws    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        add      = 1'b0;
        next_mag = 64'(num_mag) * 64'd10 + 64'(c - CH_ZERO);
        cap      = num_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (num_phase == VP_SKIP && !is_ws) begin
            if (c == CH_PLUS || c == CH_MINUS) begin
                num_neg   = (c == CH_MINUS);
                num_phase = VP_DIGITS;
            end else if (is_dig) begin
                num_phase = VP_DIGITS;
                add       = 1'b1;
            end else begin
                num_phase = VP_DONE;
            end
        end else if (num_phase == VP_DIGITS) begin
            if (is_dig) begin
                add = 1'b1;
            end else begin
                num_phase = VP_DONE;
            end
        end
        if (add) begin
            if (next_mag > cap) begin
                next_mag = cap;
                num_sat  = 1'b1;
            end
            num_mag = next_mag[31:0];
        end
    endfunction

    function automatic void frame_byte(input t_in_item req);
        logic [7:0]     c;
        logic [7:0]     lc;
        t_term_progress prior;
        logic           closed;
        logic [31:0]    body;
        t_out_item      want;
        c      = req.byte_value;
        closed = 1'b0;
        if (req.msg_start) begin
            clear_parse();
        end
        if (hdr_closed) begin
            return;
        end
        prior = term_seen;

        if (hdr_bytes == '1) begin
            cnt_sat = 1'b1;
        end else begin
            hdr_bytes = hdr_bytes + 1'b1;
        end

        // value scan and name match see the byte before a line restart
        if (length_seen) begin
            scan_value_char(c);
        end else if (name_armed) begin
            lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + 8'd32 : c;
            if (lc != LENGTH_FIELD[8*(KEYWORD_LEN-1-int'(name_pos)) +: 8]) begin
                name_armed = 1'b0;
            end else if (name_pos >= KEYWORD_LEN - 1) begin
                name_armed  = 1'b0;
                length_seen = 1'b1;
                num_phase   = VP_SKIP;
            end else begin
                name_pos = name_pos + 1'b1;
            end
        end

        if (c == CH_CR) begin
            term_seen = (prior == TP_CRLF) ? TP_CRLFCR : TP_CR;
        end else if (c == CH_LF) begin
            if (prior == TP_CR) begin
                term_seen = TP_CRLF;
                if (!length_seen) begin
                    name_armed = 1'b1;
                    name_pos   = '0;
                end
            end else begin
                closed    = (prior == TP_CRLFCR);
                term_seen = TP_NONE;
            end
        end else begin
            term_seen = TP_NONE;
        end

        if (!closed) begin
            return;
        end
        hdr_closed = 1'b1;
        body = '0;
        if (length_seen) begin
            body = num_neg ? 32'd0 - num_mag : num_mag;
        end
        want.total_length     = 33'(hdr_bytes) + {body[31], body};
        want.header_length    = 16'(hdr_bytes);
        want.body_length      = body;
        want.length_present   = length_seen;
        want.header_saturated = cnt_sat;
        want.value_saturated  = num_sat;
        pending_lengths.push_back(want);
    endfunction

    function automatic void check_field(input string field, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endfunction

    initial begin
        clear_parse();
    end

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            clear_parse();
            pending_lengths.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                frame_byte(i_in_mon.payload);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (pending_lengths.size() == 0) begin
                    $error("result with no header pending: header_length %0d",
                           i_out_mon.payload.header_length);
                    mismatches++;
                end else begin
                    want = pending_lengths.pop_front();
                    check_field("total_length", $signed(want.total_length),
                                $signed(i_out_mon.payload.total_length));
                    check_field("header_length", want.header_length,
                                i_out_mon.payload.header_length);
                    check_field("body_length", $signed(want.body_length),
                                $signed(i_out_mon.payload.body_length));
                    check_field("length_present", want.length_present,
                                i_out_mon.payload.length_present);
                    check_field("header_saturated", want.header_saturated,
                                i_out_mon.payload.header_saturated);
                    check_field("value_saturated", want.value_saturated,
                                i_out_mon.payload.value_saturated);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_lengths.size();
    end

endmodule

// File: bench/tb_top.sv
// Testbench top for the HTTP message length framer: clock, reset, message
// stimulus, receiver stalls and the verdict. Depends on hmlf_pkg, both
// channel interfaces, the framer and hmlf_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hmlf_pkg::*;

    // total bytes sent, directed headers included
    localparam int RANDOM_BYTES = 1250;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    hmlf_in_if  req_ch ();
    hmlf_out_if res_ch ();

    http_message_length_framer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    hmlf_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (req_ch),
        .i_out_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // message under construction, one byte per request
    logic [7:0]  msg_q[$];
    int          burst_left = 0;
    int          sent_bytes = 0;
    logic [15:0] stall_mask = 16'hFFFF;
    int unsigned stall_tick = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Receiver: draws rotating 16-bit ready patterns, from never stalling
    // to a single ready bit in the mask. Bit 0 always kept set in the random
    // masks so every pattern holds at least one ready bit.
    always @(posedge i_clk) begin
        if (stall_tick % 64 == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_mask = 16'hFFFF;
                1:       stall_mask = 16'h0001;
                default: stall_mask = 16'($urandom) | 16'h0001;
            endcase
        end else begin
            stall_mask = {stall_mask[14:0], stall_mask[15]};
        end
        stall_tick++;
        res_ch.ready <= stall_mask[0];
    end

    // printable filler byte
    function automatic logic [7:0] text_char();
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    // '|' stands for a CR LF pair, so lines read naturally in the strings
    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] == "|") begin
                msg_q.push_back(CH_CR);
                msg_q.push_back(CH_LF);
            end else begin
                msg_q.push_back(s[i]);
            end
        end
    endfunction

    // Field name in random case; a partial one ends in a random character,
    // giving near misses of the keyword.
    function automatic void add_field_name(input bit whole);
        string      field;
        int         cut;
        logic [7:0] ch;
        field = "content-length:";
        cut   = whole ? field.len() : $urandom_range(0, field.len() - 1);
        for (int i = 0; i < cut; i++) begin
            ch = field[i];
            if (ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) begin
                ch = ch - 8'd32;
            end
            msg_q.push_back(ch);
        end
        if (!whole) begin
            msg_q.push_back(text_char());
        end
    endfunction

    // One request: the sender runs in bursts, with a random gap (sometimes
    // none) before each new burst. valid is only lowered at the start of a
    // gap, never lowered and raised in the same step.
    task automatic send_req(input logic [7:0] b, input logic start);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid   <= 1'b1;
        req_ch.payload <= t_in_item'{byte_value: b, msg_start: start};
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic send_msg(input bit with_start);
        for (int i = 0; i < msg_q.size(); i++) begin
            send_req(msg_q[i], with_start && i == 0);
        end
        sent_bytes += msg_q.size();
        msg_q.delete();
    endtask

    task automatic send_text(input string s, input bit with_start);
        add_text(s);
        send_msg(with_start);
    endtask

    initial begin
        int    lines;
        int    cut;
        bit    with_start;
        string digits;

        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed headers ---
        send_text("||", 1'b1);                                  // shortest header
        send_text("GET / HTTP/1.1|CONTENT-LENGTH: 2147483647||", 1'b1);
        send_text("|content-length:-2147483648||", 1'b1);
        send_text("|Content-Length: 99999999999||", 1'b1);      // saturates high
        send_text("|content-length:\t-99999999999x||", 1'b1);   // saturates low
        send_text("|content-length:|  7||", 1'b1);              // value on next line
        send_text("|content-length:+|content-length: 9||", 1'b1); // bare sign, 2nd ignored
        send_text("|content-length:||", 1'b1);                  // empty value
        send_text("content-length: 5||", 1'b1);                 // first line never matched
        send_text("|Content-Lengthx: 5||", 1'b1);               // near miss
        send_text("|content-length: 3||ab||", 1'b1);            // body ignored
        send_text("xy||", 1'b0);                                // still ignored, no start
        send_text("|content-le", 1'b1);                         // restart mid-header
        send_text("||", 1'b1);

        // --- random messages ---
        // Mostly well-formed headers with random lines, values and case;
        // some noise bytes, truncated headers and missing start marks.
        while (sent_bytes < RANDOM_BYTES) begin
            repeat ($urandom_range(0, 6)) begin
                msg_q.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom) : text_char());
            end
            lines = $urandom_range(0, 2);
            repeat (lines) begin
                add_text("|");
                case ($urandom_range(0, 5))
                    0, 1, 2: begin
                        add_field_name(1'b1);
                        repeat ($urandom_range(0, 2)) begin
                            case ($urandom_range(0, 5))
                                0, 1, 2: msg_q.push_back(CH_SPACE);
                                3:       msg_q.push_back(CH_TAB);
                                4:       msg_q.push_back(8'($urandom_range(8'h0B, 8'h0C)));
                                default: add_text("|");
                            endcase
                        end
                        case ($urandom_range(0, 5))
                            0:       msg_q.push_back(CH_PLUS);
                            1:       msg_q.push_back(CH_MINUS);
                            default: ;
                        endcase
                        case ($urandom_range(0, 6))
                            0, 1: digits = $sformatf("%0d", $urandom_range(0, 999));
                            2:    digits = $sformatf("%0d", $urandom);
                            3: begin
                                case ($urandom_range(0, 3))
                                    0:       digits = "2147483647";
                                    1:       digits = "2147483648";
                                    2:       digits = "2147483649";
                                    default: digits = "0000000000042";
                                endcase
                            end
                            4:       digits = $sformatf("%0d%0d", $urandom,
                                                        $urandom_range(0, 999));
                            5:       digits = "";
                            default: digits = "0";
                        endcase
                        add_text(digits);
                        if ($urandom_range(0, 3) == 0) begin
                            add_text("; q");
                        end
                    end
                    3: add_field_name(1'b0);
                    default: begin
                        add_text("x-");
                        repeat ($urandom_range(1, 5)) msg_q.push_back(text_char());
                        add_text(": ");
                        repeat ($urandom_range(0, 6)) msg_q.push_back(text_char());
                    end
                endcase
            end
            add_text("||");
            // body bytes, any value, sometimes with a terminator inside
            repeat ($urandom_range(0, 6)) msg_q.push_back(8'($urandom));
            if ($urandom_range(0, 5) == 0) begin
                add_text("||");
            end
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, msg_q.size());
                while (msg_q.size() > cut) begin
                    void'(msg_q.pop_back());
                end
            end
            with_start = ($urandom_range(0, 19) != 0);
            send_msg(with_start);
        end

        req_ch.valid <= 1'b0;
        // let the last request be counted, then drain
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // run limit: several times the slowest legal run of about 1300 requests
    // under the longest sender gaps and receiver stalls
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
design/hmlf_pkg.sv
design/hmlf_in_if.sv
design/hmlf_out_if.sv
design/hmlf_step.sv
design/http_message_length_framer.sv
bench/hmlf_checker.sv
bench/tb_top.sv
